/* src/msda_pkg.sv */
// Shared types, constants and helper functions of the dose alarm controller.
package msda_pkg;

  localparam int unsigned NUM_PLANS     = 4;
  localparam int unsigned DEF_SLOTS     = 4;
  localparam int unsigned PLAN_W        = 12;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned MIN_PER_DAY   = 1440;

  localparam logic [2:0] NONE_SLOT = 3'd4;
  localparam logic [5:0] UNSET6    = 6'd63;
  localparam logic [4:0] UNSET5    = 5'd31;

  localparam logic [PLAN_W-1:0] PLAN_RESET    = 12'd512;
  localparam logic [5:0]        SNOOZE_RESET  = 6'd5;
  localparam logic [7:0]        TIMEOUT_RESET = 8'd10;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_CONFIRM   = 2'd1,
    ACT_SNOOZE    = 2'd2,
    ACT_DAY_RESET = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RING   = 2'd1,
    MODE_MISSED = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_PLAN_A     = 3'd0,
    CFG_PLAN_B     = 3'd1,
    CFG_PLAN_C     = 3'd2,
    CFG_PLAN_D     = 3'd3,
    CFG_SNOOZE_MIN = 3'd4,
    CFG_TIMEOUT    = 3'd5
  } cfg_idx_e;

  typedef logic [NUM_PLANS-1:0][PLAN_W-1:0] plan_t;

  typedef struct packed {
    action_e    action;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  ringing_slot;
    logic [5:0]  seen_day;
    logic [2:0]  last_slot;
    logic [5:0]  last_day;
    logic [4:0]  last_hour;
    logic [5:0]  last_minute;
    logic [7:0]  elapsed;
    logic [5:0]  last_second;
    logic [2:0]  snooze_slot;
    logic [15:0] snooze_due;
    logic        beep;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    mode:         MODE_NORMAL,
    ringing_slot: NONE_SLOT,
    seen_day:     UNSET6,
    last_slot:    NONE_SLOT,
    last_day:     UNSET6,
    last_hour:    UNSET5,
    last_minute:  UNSET6,
    elapsed:      8'd0,
    last_second:  UNSET6,
    snooze_slot:  NONE_SLOT,
    snooze_due:   16'd0,
    beep:         1'b0
  };

  typedef struct packed {
    logic [1:0] next_slot;
    logic       next_valid;
    logic [7:0] snooze_left;
    logic [1:0] snooze_slot;
    logic       snooze_active;
    logic [2:0] enabled_count;
    logic [2:0] taken_count;
    logic       beep_on;
    logic [2:0] alarm_slot;
    logic [1:0] mode;
  } result_t;

  // Absolute minute count within the month; the largest value fits in 16 bits.
  function automatic logic [15:0] now_minutes(input logic [4:0] day, input logic [4:0] hour,
                                              input logic [5:0] minute);
    return 16'(day) * 16'(MIN_PER_DAY) + 16'(hour) * 16'(MIN_PER_HOUR) + 16'(minute);
  endfunction

  function automatic logic [10:0] day_minutes(input logic [4:0] hour, input logic [5:0] minute);
    return 11'(hour) * 11'(MIN_PER_HOUR) + 11'(minute);
  endfunction

  function automatic logic plan_en(input logic [PLAN_W-1:0] p);
    return p[11];
  endfunction

  function automatic logic [4:0] plan_hour(input logic [PLAN_W-1:0] p);
    return p[10:6];
  endfunction

  function automatic logic [5:0] plan_min(input logic [PLAN_W-1:0] p);
    return p[5:0];
  endfunction

  // Back to normal with the buzzer off and the ring bookkeeping dropped.
  function automatic ctrl_t quiet(input ctrl_t c);
    ctrl_t r;
    r              = c;
    r.beep         = 1'b0;
    r.elapsed      = 8'd0;
    r.last_second  = UNSET6;
    r.ringing_slot = NONE_SLOT;
    r.mode         = MODE_NORMAL;
    return r;
  endfunction

endpackage

/* src/msda_core.sv */
// Next-state logic: day rollover, alarm start, ring timeout, confirm, snooze and daily reset.
module msda_core #(
  parameter int unsigned SLOTS = msda_pkg::DEF_SLOTS
) (
  input  msda_pkg::item_t                      item_i,
  input  msda_pkg::ctrl_t                      ctrl_i,
  input  logic [SLOTS-1:0]                     taken_i,
  input  logic [SLOTS-1:0][5:0]                tod_i,
  input  logic [SLOTS-1:0][msda_pkg::PLAN_W-1:0] plan_i,
  input  logic [5:0]                           snooze_min_i,
  input  logic [7:0]                           timeout_i,
  output msda_pkg::ctrl_t                      ctrl_o,
  output logic [SLOTS-1:0]                     taken_o,
  output logic [SLOTS-1:0][5:0]                tod_o
);

  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [2:0]  SLOT_LIMIT = 3'(SLOTS);

  msda_pkg::ctrl_t         c;
  logic [SLOTS-1:0]        tk;
  logic [SLOTS-1:0][5:0]   td;
  logic [SLOTS-1:0]        match;
  logic [5:0]              day6;
  logic [15:0]             now_min;
  logic                    start;
  logic [SLOT_W-1:0]       start_slot;
  logic [SLOT_W-1:0]       pick;
  logic [SLOT_W-1:0]       sidx;
  logic [SLOT_W-1:0]       ridx;
  logic [7:0]              el;

  always_comb begin
    day6    = {1'b0, item_i.day};
    now_min = msda_pkg::now_minutes(item_i.day, item_i.hour, item_i.minute);
    c       = ctrl_i;
    tk      = taken_i;
    td      = tod_i;
    start   = 1'b0;
    start_slot = '0;
    sidx    = c.snooze_slot[SLOT_W-1:0];
    ridx    = c.ringing_slot[SLOT_W-1:0];
    el      = c.elapsed;

    // A taken mark only counts on the day it was set.
    for (int i = 0; i < SLOTS; i++) begin
      if (td[i] != day6) tk[i] = 1'b0;
    end

    if (c.seen_day == msda_pkg::UNSET6) c.seen_day = day6;
    if (day6 != c.seen_day) begin
      tk            = '0;
      td            = {SLOTS{msda_pkg::UNSET6}};
      c.seen_day    = day6;
      c.last_slot   = msda_pkg::NONE_SLOT;
      c.last_day    = msda_pkg::UNSET6;
      c.last_hour   = msda_pkg::UNSET5;
      c.last_minute = msda_pkg::UNSET6;
      c.ringing_slot = msda_pkg::NONE_SLOT;
      c.mode        = msda_pkg::MODE_NORMAL;
      c.beep        = 1'b0;
    end

    // Plan matches; an alarm fires once per slot and minute.
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = msda_pkg::plan_en(plan_i[i]) && !tk[i] &&
                 !(c.last_slot == 3'(i) && c.last_day == day6 &&
                   c.last_hour == item_i.hour && c.last_minute == item_i.minute) &&
                 msda_pkg::plan_hour(plan_i[i]) == item_i.hour &&
                 msda_pkg::plan_min(plan_i[i]) == item_i.minute;
    end
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) pick = SLOT_W'(i);
    end

    case (item_i.action)
      msda_pkg::ACT_TICK: begin
        case (c.mode)
          msda_pkg::MODE_NORMAL: begin
            if (c.snooze_slot < SLOT_LIMIT) begin
              if (!msda_pkg::plan_en(plan_i[sidx]) || tk[sidx]) begin
                c.snooze_slot = msda_pkg::NONE_SLOT;
                c.snooze_due  = 16'd0;
              end else if (now_min >= c.snooze_due) begin
                c.snooze_slot = msda_pkg::NONE_SLOT;
                c.snooze_due  = 16'd0;
                start         = 1'b1;
                start_slot    = sidx;
              end
            end
            if (!start && (|match)) begin
              start      = 1'b1;
              start_slot = pick;
            end
          end
          msda_pkg::MODE_RING: begin
            if (c.ringing_slot >= SLOT_LIMIT) begin
              c = msda_pkg::quiet(c);
            end else begin
              if (item_i.second != c.last_second) begin
                c.last_second = item_i.second;
                if (el != 8'hFF) el = el + 8'd1;
              end
              c.elapsed = el;
              if (c.elapsed >= timeout_i || item_i.hour != c.last_hour ||
                  item_i.minute != c.last_minute) begin
                tk[ridx]      = 1'b0;
                c.beep        = 1'b0;
                c.elapsed     = 8'd0;
                c.last_second = msda_pkg::UNSET6;
                c.mode        = msda_pkg::MODE_MISSED;
              end else begin
                c.beep = ~item_i.second[0];
              end
            end
          end
          default: begin
          end
        endcase
      end
      msda_pkg::ACT_CONFIRM: begin
        if (c.mode == msda_pkg::MODE_RING && c.ringing_slot < SLOT_LIMIT) begin
          tk[ridx] = 1'b1;
          td[ridx] = day6;
        end
        c.snooze_slot = msda_pkg::NONE_SLOT;
        c.snooze_due  = 16'd0;
        c = msda_pkg::quiet(c);
      end
      msda_pkg::ACT_SNOOZE: begin
        if (c.mode == msda_pkg::MODE_RING && c.ringing_slot < SLOT_LIMIT) begin
          c.snooze_slot = c.ringing_slot;
          c.snooze_due  = now_min + 16'(snooze_min_i);
        end
        c = msda_pkg::quiet(c);
      end
      default: begin
        tk = '0;
        td = {SLOTS{msda_pkg::UNSET6}};
      end
    endcase

    if (start) begin
      c.mode         = msda_pkg::MODE_RING;
      c.ringing_slot = 3'(start_slot);
      c.last_slot    = 3'(start_slot);
      c.last_day     = day6;
      c.last_hour    = item_i.hour;
      c.last_minute  = item_i.minute;
      c.elapsed      = 8'd0;
      c.last_second  = item_i.second;
      c.beep         = 1'b1;
    end

    ctrl_o  = c;
    taken_o = tk;
    tod_o   = td;
  end

endmodule

/* src/msda_status.sv */
// Result fields: slot counts, nearest upcoming dose and snooze countdown.
module msda_status #(
  parameter int unsigned SLOTS = msda_pkg::DEF_SLOTS
) (
  input  msda_pkg::item_t                        item_i,
  input  msda_pkg::ctrl_t                        ctrl_i,
  input  logic [SLOTS-1:0]                       taken_i,
  input  logic [SLOTS-1:0][msda_pkg::PLAN_W-1:0] plan_i,
  output msda_pkg::result_t                      res_o
);

  localparam logic [2:0] SLOT_LIMIT = 3'(SLOTS);
  // Larger than any distance, which stays below two days of minutes.
  localparam logic signed [12:0] DIST_MAX = 13'sd4095;

  logic [10:0]        nm;
  logic [15:0]        now_min;
  logic [15:0]        left;
  logic signed [12:0] diff;
  logic signed [12:0] best;
  logic [2:0]         en_cnt;
  logic [2:0]         tk_cnt;
  logic [1:0]         nslot;
  logic               nvalid;

  always_comb begin
    nm      = msda_pkg::day_minutes(item_i.hour, item_i.minute);
    now_min = msda_pkg::now_minutes(item_i.day, item_i.hour, item_i.minute);
    best    = DIST_MAX;
    en_cnt  = 3'd0;
    tk_cnt  = 3'd0;
    nslot   = 2'd0;
    nvalid  = 1'b0;
    diff    = 13'sd0;
    left    = 16'd0;

    // Taken slots are pushed to tomorrow, as are times already past today.
    for (int i = 0; i < SLOTS; i++) begin
      if (msda_pkg::plan_en(plan_i[i])) begin
        en_cnt = en_cnt + 3'd1;
        if (taken_i[i]) tk_cnt = tk_cnt + 3'd1;
        diff = $signed({2'b00, msda_pkg::day_minutes(msda_pkg::plan_hour(plan_i[i]),
                                                     msda_pkg::plan_min(plan_i[i]))}) -
               $signed({2'b00, nm});
        if (taken_i[i] || diff < 13'sd0) diff = diff + 13'(msda_pkg::MIN_PER_DAY);
        if (diff < best) begin
          best   = diff;
          nslot  = 2'(i);
          nvalid = 1'b1;
        end
      end
    end

    res_o               = '0;
    res_o.mode          = ctrl_i.mode;
    res_o.alarm_slot    = ctrl_i.ringing_slot;
    res_o.beep_on       = ctrl_i.beep;
    res_o.taken_count   = tk_cnt;
    res_o.enabled_count = en_cnt;
    res_o.next_valid    = nvalid;
    res_o.next_slot     = nslot;
    if (ctrl_i.snooze_slot < SLOT_LIMIT) begin
      res_o.snooze_active = 1'b1;
      res_o.snooze_slot   = ctrl_i.snooze_slot[1:0];
      if (ctrl_i.snooze_due > now_min) begin
        left = ctrl_i.snooze_due - now_min;
        res_o.snooze_left = (left > 16'd255) ? 8'hFF : left[7:0];
      end
    end
  end

endmodule

/* src/multi_slot_dose_alarm_controller_unit.sv */
// Top level of the four-slot daily dose alarm controller.
// Each input transaction is one event (tick, confirm, snooze or daily reset) with the
// current day and time; it yields exactly one result transaction with mode, buzzer drive,
// slot counts, snooze countdown and the next upcoming dose. An event is held in an
// input register and is evaluated in a single pass into the state and result registers,
// so the block takes one transaction per cycle while the result side keeps up. Plans and
// timing must be written through the configuration channel only while no event is in
// flight; the block does not enforce this, and writes are always accepted.
module multi_slot_dose_alarm_controller_unit #(
  parameter int unsigned SLOTS = msda_pkg::DEF_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // day[4:0], hour[9:5], minute[15:10], second[21:16]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode[1:0], alarm_slot[4:2], beep_on[5], taken_count[8:6], enabled_count[11:9],
  // snooze_active[12], snooze_slot[14:13], snooze_left[22:15], next_valid[23],
  // next_slot[25:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam logic [2:0] SLOT_LIMIT = 3'(SLOTS);

  msda_pkg::item_t                        in_item_q;
  logic                                   in_valid_q;
  msda_pkg::result_t                      res_d, res_q;
  logic                                   out_valid_q;
  msda_pkg::ctrl_t                        ctrl_d, ctrl_q;
  logic [SLOTS-1:0]                       taken_d, taken_q;
  logic [SLOTS-1:0][5:0]                  tod_d, tod_q;
  msda_pkg::plan_t                        plan_q;
  logic [5:0]                             snooze_min_q;
  logic [7:0]                             timeout_q;
  logic                                   step;
  logic                                   in_take;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.action <= msda_pkg::action_e'(s_axis_tuser);
      in_item_q.day    <= s_axis_tdata[4:0];
      in_item_q.hour   <= s_axis_tdata[9:5];
      in_item_q.minute <= s_axis_tdata[15:10];
      in_item_q.second <= s_axis_tdata[21:16];
    end
  end

  msda_core #(
    .SLOTS(SLOTS)
  ) u_core (
    .item_i      (in_item_q),
    .ctrl_i      (ctrl_q),
    .taken_i     (taken_q),
    .tod_i       (tod_q),
    .plan_i      (plan_q[SLOTS-1:0]),
    .snooze_min_i(snooze_min_q),
    .timeout_i   (timeout_q),
    .ctrl_o      (ctrl_d),
    .taken_o     (taken_d),
    .tod_o       (tod_d)
  );

  msda_status #(
    .SLOTS(SLOTS)
  ) u_status (
    .item_i (in_item_q),
    .ctrl_i (ctrl_d),
    .taken_i(taken_d),
    .plan_i (plan_q[SLOTS-1:0]),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= msda_pkg::CTRL_RESET;
      taken_q     <= '0;
      tod_q       <= {SLOTS{msda_pkg::UNSET6}};
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        ctrl_q  <= ctrl_d;
        taken_q <= taken_d;
        tod_q   <= tod_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q       <= {msda_pkg::NUM_PLANS{msda_pkg::PLAN_RESET}};
      snooze_min_q <= msda_pkg::SNOOZE_RESET;
      timeout_q    <= msda_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        msda_pkg::CFG_PLAN_A:     plan_q[0]    <= cfg_data_i;
        msda_pkg::CFG_PLAN_B:     plan_q[1]    <= cfg_data_i;
        msda_pkg::CFG_PLAN_C:     plan_q[2]    <= cfg_data_i;
        msda_pkg::CFG_PLAN_D:     plan_q[3]    <= cfg_data_i;
        msda_pkg::CFG_SNOOZE_MIN: snooze_min_q <= cfg_data_i[5:0];
        msda_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q};

`ifndef SYNTH
  // The buzzer is only driven while an alarm rings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.beep |-> ctrl_q.mode == msda_pkg::MODE_RING)
    else $error("beep active outside ringing mode");

  // A missed alarm has its second counter cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.mode == msda_pkg::MODE_MISSED |-> ctrl_q.elapsed == 8'd0)
    else $error("elapsed seconds not cleared in missed mode");

  // A ringing alarm always belongs to a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.mode == msda_pkg::MODE_RING |-> ctrl_q.ringing_slot < SLOT_LIMIT)
    else $error("ringing without a valid slot");

  // Snooze slot and due time are set and dropped together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.snooze_slot >= SLOT_LIMIT |->
      (ctrl_q.snooze_slot == msda_pkg::NONE_SLOT && ctrl_q.snooze_due == 16'd0))
    else $error("stale snooze state");
`endif

endmodule
